// ===== hdl/usf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usf_pkg
// Shared types and constants of the UTF-8 structural filter.
// ----------------------------------------------------------------------------
package usf_pkg;

  // Byte class masks and tags.
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Tag  = 8'hF0;

  // Number of held bytes (lead plus continuation bytes before the final one).
  localparam int HeldDepth = 3;

  // Default depth of the queue between the front and back parts.
  localparam int QueueDepth = 4;

  // One burst of results caused by one input item.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes to emit, in order
    logic [1:0]      last_idx;  // index of the final byte of the burst
    logic            present;   // 0 for an end marker that carries no byte
    logic            str_end;   // burst closes the string
  } usf_desc_t;

  // Push request from the front part to the queue.
  typedef struct packed {
    logic      push;
    usf_desc_t desc;
  } usf_push_t;

endpackage : usf_pkg
`default_nettype wire

// ===== hdl/usf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usf_in_if / usf_out_if
// Valid/ready channels for input bytes and filtered result items.
// ----------------------------------------------------------------------------
interface usf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface : usf_in_if

interface usf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output byte_present,
                  output run_end, output string_end, input ready);
  modport sink   (input valid, input out_byte, input byte_present,
                  input run_end, input string_end, output ready);
endinterface : usf_out_if
`default_nettype wire

// ===== hdl/usf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usf_front
// Accepts bytes, tracks the pending sequence and builds result bursts.
// ----------------------------------------------------------------------------
module usf_front (
  input  wire logic            clk,
  input  wire logic            rst,
  usf_in_if.sink               in_ch,
  input  wire logic            q_full,
  output usf_pkg::usf_push_t   req
);

  logic [7:0] held [usf_pkg::HeldDepth];
  logic [1:0] held_count, held_count_next;
  logic [1:0] needed_count, needed_count_next;

  logic             accept;
  logic             cont;
  logic             emit;
  logic             wr_held;
  logic [1:0]       wr_idx;
  usf_pkg::usf_desc_t desc;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign cont        = (in_ch.in_byte & usf_pkg::ContMask) == usf_pkg::ContTag;

  // Classify the byte against the pending sequence and form the burst.
  always_comb begin
    held_count_next   = held_count;
    needed_count_next = needed_count;
    emit              = 1'b0;
    wr_held           = 1'b0;
    wr_idx            = held_count;
    desc              = '0;
    if (needed_count != 2'd0 && cont) begin
      needed_count_next = needed_count - 2'd1;
      if (needed_count == 2'd1) begin
        // Sequence complete: held bytes followed by this one.
        emit = 1'b1;
        for (int i = 0; i < usf_pkg::HeldDepth; i++) begin
          if (i < int'(held_count)) begin
            desc.bytes[i] = held[i];
          end
        end
        desc.bytes[held_count] = in_ch.in_byte;
        desc.last_idx          = held_count;
        held_count_next        = 2'd0;
      end else if (held_count != 2'd3) begin
        wr_held         = 1'b1;
        held_count_next = held_count + 2'd1;
      end
    end else begin
      // No sequence pending, or it broke off: judge the byte as a lead.
      held_count_next   = 2'd0;
      needed_count_next = 2'd0;
      wr_idx            = 2'd0;
      if (!in_ch.in_byte[7]) begin
        emit          = 1'b1;
        desc.bytes[0] = in_ch.in_byte;
      end else if ((in_ch.in_byte & usf_pkg::Lead2Mask) == usf_pkg::Lead2Tag) begin
        wr_held = 1'b1; held_count_next = 2'd1; needed_count_next = 2'd1;
      end else if ((in_ch.in_byte & usf_pkg::Lead3Mask) == usf_pkg::Lead3Tag) begin
        wr_held = 1'b1; held_count_next = 2'd1; needed_count_next = 2'd2;
      end else if ((in_ch.in_byte & usf_pkg::Lead4Mask) == usf_pkg::Lead4Tag) begin
        wr_held = 1'b1; held_count_next = 2'd1; needed_count_next = 2'd3;
      end
    end
    // The end of the string drops any pending sequence.
    if (in_ch.in_last) begin
      held_count_next   = 2'd0;
      needed_count_next = 2'd0;
    end
    desc.present = emit;
    desc.str_end = in_ch.in_last;
  end

  assign req.push = accept && (emit || in_ch.in_last);
  assign req.desc = desc;

  // Sequence state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      needed_count <= 2'd0;
    end else if (accept) begin
      held_count   <= held_count_next;
      needed_count <= needed_count_next;
    end
  end

  // Held byte storage.
  always_ff @(posedge clk) begin
    if (accept && wr_held && wr_idx != 2'd3) begin
      held[wr_idx] <= in_ch.in_byte;
    end
  end

  // A pending sequence always has its lead byte held, and never more than four bytes.
  assert property (@(posedge clk) disable iff (rst)
    (needed_count == 2'd0) == (held_count == 2'd0))
    else $error("held and needed counts disagree");
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, held_count} + {1'b0, needed_count}) <= 3'd4)
    else $error("pending sequence longer than four bytes");

endmodule : usf_front
`default_nettype wire

// ===== hdl/usf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usf_queue
// Short queue of result bursts between the front and back parts.
// ----------------------------------------------------------------------------
module usf_queue #(
  parameter int Depth = usf_pkg::QueueDepth
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire usf_pkg::usf_push_t  req,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output usf_pkg::usf_desc_t       head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  usf_pkg::usf_desc_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;

  assign full      = fill == CntW'(Depth);
  assign not_empty = fill != '0;
  assign head      = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[wr_ptr] <= req.desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (req.push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (req.push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !req.push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) req.push |-> !full)
    else $error("push into a full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from an empty queue");

endmodule : usf_queue
`default_nettype wire

// ===== hdl/usf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usf_back
// Emits each burst via an output register, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module usf_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                not_empty,
  input  wire usf_pkg::usf_desc_t  head,
  output logic                     pop,
  usf_out_if.source                out_ch
);

  logic [1:0] idx;
  logic       take;
  logic       load;
  logic       at_last;

  assign take    = !out_ch.valid || out_ch.ready;
  assign load    = take && not_empty;
  assign at_last = idx == head.last_idx;
  assign pop     = load && at_last;

  // Output register valid and burst position.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      idx          <= 2'd0;
    end else if (take) begin
      out_ch.valid <= not_empty;
      if (load) begin
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.out_byte     <= head.bytes[idx];
      out_ch.byte_present <= head.present;
      out_ch.run_end      <= at_last;
      out_ch.string_end   <= at_last && head.str_end;
    end
  end

  // The burst position never runs past the final byte of the burst at the head.
  assert property (@(posedge clk) disable iff (rst) not_empty |-> idx <= head.last_idx)
    else $error("burst index past end of burst");

endmodule : usf_back
`default_nettype wire

// ===== hdl/utf8_structural_filter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_structural_filter_unit
// Streaming filter that passes only structurally well-formed UTF-8.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and emits each complete sequence of one
// to four bytes whole, once its final byte has arrived; stray continuation
// bytes, invalid leads and broken or unfinished sequences are dropped. An
// input marked last always yields at least one result, with a marker that
// carries no byte when nothing else is emitted. A byte is accepted every cycle
// while the burst queue (QueueDepth entries) has room; the output side emits
// one result per cycle while the receiver is ready, and the input stalls only
// when the queue fills. The first result of a sequence is written into the
// burst queue, then loaded into the output register and presented there.
// ----------------------------------------------------------------------------
module utf8_structural_filter_unit #(
  parameter int QueueDepth = usf_pkg::QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  usf_in_if.sink    in_ch,
  usf_out_if.source out_ch
);

  usf_pkg::usf_push_t req;
  usf_pkg::usf_desc_t head;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;

  // Sequence tracking and burst building.
  usf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .req    (req)
  );

  // Burst queue.
  usf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // Result serialization.
  usf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .head      (head),
    .pop       (q_pop),
    .out_ch    (out_ch)
  );

endmodule : utf8_structural_filter_unit
`default_nettype wire

// ===== bench/tb_utf8_structural_filter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_structural_filter_unit
// Self-checking bench for the streaming UTF-8 structural filter.
// ----------------------------------------------------------------------------
// A short table of directed strings covers the byte-range extremes, each lead
// class, broken, stray and unfinished sequences, and end markers. Random
// strings follow, built mostly from well-formed characters with random
// payload bits, mixed with truncated sequences, stray continuation bytes and
// invalid leads. A behavioral model predicts the results, typed rows apart, and
// each result taken from the block is compared field by field with the
// oldest prediction. Both handshake sides idle at random in several phases,
// and one long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_utf8_structural_filter_unit;

  // One result item as the block emits it.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       run_end;
    logic       str_end;
  } filt_res_t;

  // One directed stimulus row; typed rows carry their single expected result.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] exp_data;
    logic       exp_present;
  } dir_row_t;

  localparam int NumDirRows = 25;
  localparam int PhaseItems = 75;
  localparam int HoldCycles = 60;
  localparam int DrainCycles = 8;

  localparam dir_row_t DirRows [NumDirRows] = '{
    '{8'h01, 1'b1, 1'b1, 8'h01, 1'b1},  // smallest nonzero ASCII byte ends a string
    '{8'h7F, 1'b1, 1'b1, 8'h7F, 1'b1},  // largest ASCII byte ends a string
    '{8'h80, 1'b1, 1'b1, 8'h00, 1'b0},  // stray continuation gives a marker
    '{8'hFF, 1'b1, 1'b1, 8'h00, 1'b0},  // invalid lead gives a marker
    '{8'hF8, 1'b0, 1'b0, 8'h00, 1'b0},  // smallest invalid lead is dropped
    '{8'hC2, 1'b0, 1'b0, 8'h00, 1'b0},  // two-byte character
    '{8'hA9, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 8'h00, 1'b0},  // three-byte character
    '{8'h82, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hAC, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 8'h00, 1'b0},  // four-byte character closing a string
    '{8'h9F, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h98, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 8'h00, 1'b0},  // broken sequence, ASCII judged again
    '{8'h41, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hE0, 1'b0, 1'b0, 8'h00, 1'b0},  // broken sequence, new lead follows
    '{8'hC2, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 8'h00, 1'b0},  // unfinished sequence at string end
    '{8'h8F, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h8F, 1'b1, 1'b1, 8'h00, 1'b0},
    '{8'hDF, 1'b1, 1'b1, 8'h00, 1'b0},  // lone lead as the last byte
    '{8'hBF, 1'b0, 1'b0, 8'h00, 1'b0},  // stray continuation mid-string
    '{8'h20, 1'b1, 1'b1, 8'h20, 1'b1}
  };

  logic clk = 1'b0;
  logic rst;

  usf_in_if  in_ch ();
  usf_out_if out_ch ();

  utf8_structural_filter_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted result items, oldest first.
  filt_res_t filtered_q [$];

  // Predictor copy of the pending sequence.
  logic [7:0] seq_held [3];
  int unsigned seq_held_n;
  int unsigned seq_need_n;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent;
  int unsigned mismatches = 0;
  logic        hold_req;
  bit          hold_used = 1'b0;
  int unsigned hold_left = 0;

  function automatic void seq_clear();
    seq_held   = '{8'h00, 8'h00, 8'h00};
    seq_held_n = 0;
    seq_need_n = 0;
  endfunction

  function automatic filt_res_t data_res(input logic [7:0] b);
    filt_res_t r;
    r = '{data: b, present: 1'b1, run_end: 1'b0, str_end: 1'b0};
    return r;
  endfunction

  // Works out the result items that one input byte causes.
  task automatic filter_step(input logic [7:0] b, input logic last,
                             output filt_res_t burst [$]);
    bit consumed;
    consumed = 1'b0;
    burst = {};
    if (seq_need_n != 0) begin
      if ((b & usf_pkg::ContMask) == usf_pkg::ContTag) begin
        seq_need_n--;
        if (seq_need_n == 0) begin
          for (int i = 0; i < seq_held_n; i++) burst.insert(burst.size(), data_res(seq_held[i]));
          burst.insert(burst.size(), data_res(b));
          seq_clear();
        end else if (seq_held_n < usf_pkg::HeldDepth) begin
          seq_held[seq_held_n] = b;
          seq_held_n++;
        end
        consumed = 1'b1;
      end else begin
        seq_clear();
      end
    end
    // A byte that does not continue a sequence is judged as a lead.
    if (!consumed) begin
      if (b[7] == 1'b0) begin
        burst.insert(burst.size(), data_res(b));
      end else if ((b & usf_pkg::Lead2Mask) == usf_pkg::Lead2Tag) begin
        seq_held[0] = b; seq_held_n = 1; seq_need_n = 1;
      end else if ((b & usf_pkg::Lead3Mask) == usf_pkg::Lead3Tag) begin
        seq_held[0] = b; seq_held_n = 1; seq_need_n = 2;
      end else if ((b & usf_pkg::Lead4Mask) == usf_pkg::Lead4Tag) begin
        seq_held[0] = b; seq_held_n = 1; seq_need_n = 3;
      end
    end
    // The end of a string drops any pending sequence and always yields a result.
    if (last) begin
      seq_clear();
      if (burst.size() == 0) burst.insert(0, filt_res_t'(0));
      burst[burst.size() - 1].str_end = 1'b1;
    end
    if (burst.size() > 0) burst[burst.size() - 1].run_end = 1'b1;
  endtask

  // Offers one byte, waits for its handshake and records the expected results.
  task automatic send_item(input logic [7:0] b, input logic last, input bit typed,
                           input filt_res_t typed_res);
    filt_res_t burst [$];
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    filter_step(b, last, burst);
    if (typed) filtered_q.insert(filtered_q.size(), typed_res);
    else foreach (burst[i]) filtered_q.insert(filtered_q.size(), burst[i]);
  endtask

  // Builds one random string, mostly well-formed characters, and sends it.
  task automatic send_random_string();
    logic [7:0] str [$];
    int unsigned n_chars;
    int unsigned kind;
    int unsigned len;
    int unsigned n_cont;
    logic [7:0] lead;
    n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
    for (int c = 0; c < n_chars; c++) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(2, 4);
      case (len)
        2:       lead = usf_pkg::Lead2Tag | 8'($urandom_range(0, 31));
        3:       lead = usf_pkg::Lead3Tag | 8'($urandom_range(0, 15));
        default: lead = usf_pkg::Lead4Tag | 8'($urandom_range(0, 7));
      endcase
      if (kind < 75) begin
        // Well-formed character of one to four bytes.
        if ($urandom_range(0, 3) == 0) begin
          str.insert(str.size(), 8'($urandom_range(1, 127)));
        end else begin
          str.insert(str.size(), lead);
          for (int k = 1; k < len; k++)
            str.insert(str.size(), usf_pkg::ContTag | 8'($urandom_range(0, 63)));
        end
      end else if (kind < 85) begin
        // Truncated sequence.
        n_cont = $urandom_range(0, len - 2);
        str.insert(str.size(), lead);
        for (int k = 0; k < n_cont; k++)
          str.insert(str.size(), usf_pkg::ContTag | 8'($urandom_range(0, 63)));
      end else if (kind < 93) begin
        str.insert(str.size(), usf_pkg::ContTag | 8'($urandom_range(0, 63)));
      end else begin
        str.insert(str.size(), usf_pkg::Lead4Mask | 8'($urandom_range(0, 7)));
      end
    end
    foreach (str[i]) send_item(str[i], i == str.size() - 1, 1'b0, '0);
  endtask

  // Result side: check each accepted result against the oldest prediction.
  always @(posedge clk) begin : result_check
    filt_res_t got;
    filt_res_t exp_res;
    if (out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_byte, out_ch.byte_present, out_ch.run_end, out_ch.string_end};
      if (filtered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result item byte=%02h present=%b run_end=%b str_end=%b",
                   $realtime, got.data, got.present, got.run_end, got.str_end);
      end else begin
        exp_res = filtered_q.pop_front();
        if (got.data !== exp_res.data || got.present !== exp_res.present ||
            got.run_end !== exp_res.run_end || got.str_end !== exp_res.str_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch expected %02h/%b/%b/%b got %02h/%b/%b/%b",
                     $realtime, exp_res.data, exp_res.present, exp_res.run_end,
                     exp_res.str_end, got.data, got.present, got.run_end, got.str_end);
        end
      end
    end
  end

  // Receiver ready; a long hold-off lets the block fill up and stall its input.
  always @(posedge clk) begin : recv_ready
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // Reset, directed table, random phases, then drain and verdict.
  initial begin : stimulus
    filt_res_t typed_res;
    int unsigned target;
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= 8'h00;
    in_ch.in_last  <= 1'b0;
    hold_req       <= 1'b0;
    send_idle_pct  = 0;
    items_sent     = 0;
    seq_clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DirRows[i]) begin
      typed_res = '{DirRows[i].exp_data, DirRows[i].exp_present, 1'b1, 1'b1};
      send_item(DirRows[i].data, DirRows[i].last, DirRows[i].typed, typed_res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req <= 1'b1; end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      target = items_sent + PhaseItems;
      while (items_sent < target) send_random_string();
    end
    in_ch.valid <= 1'b0;

    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin : run_limit
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule : tb_utf8_structural_filter_unit
